// ----- sv/i2c_bit_level_master_defines.svh -----
// Assertion macros for the I2C master bit engine.
// Needs no other file; define NO_ASSERTIONS to compile the checks away.
`ifndef I2C_BIT_LEVEL_MASTER_DEFINES_SVH
`define I2C_BIT_LEVEL_MASTER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, held off while reset is asserted.
`define I2CBM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i2cbm check failed");
// Next-cycle implication, held off while reset is asserted.
`define I2CBM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2cbm check failed");
`else
`define I2CBM_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define I2CBM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- sv/i2cbm_pkg.sv -----
// Shared types, codes and helper functions of the I2C master bit engine.
// Used by i2cbm_fsm and the top level i2c_bit_level_master; depends on nothing.
package i2cbm_pkg;

    // sequence steps
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ST_A = 4'd1;
    localparam logic [3:0] S_ST_B = 4'd2;
    localparam logic [3:0] S_SP_A = 4'd3;
    localparam logic [3:0] S_SP_B = 4'd4;
    localparam logic [3:0] S_TX_D = 4'd5;
    localparam logic [3:0] S_TX_H = 4'd6;
    localparam logic [3:0] S_TX_L = 4'd7;
    localparam logic [3:0] S_WA_R = 4'd8;
    localparam logic [3:0] S_WA_H = 4'd9;
    localparam logic [3:0] S_WA_P = 4'd10;
    localparam logic [3:0] S_RD_L = 4'd11;
    localparam logic [3:0] S_RD_H = 4'd12;
    localparam logic [3:0] S_RK_L = 4'd13;
    localparam logic [3:0] S_RK_H = 4'd14;

    // opcodes
    localparam logic [2:0] OP_START = 3'd0;
    localparam logic [2:0] OP_STOP  = 3'd1;
    localparam logic [2:0] OP_SEND  = 3'd2;
    localparam logic [2:0] OP_WACK  = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_ACK_POLL_LIMIT  = 2'd0;
    localparam logic [1:0] CFG_START_STOP_HOLD = 2'd1;
    localparam logic [1:0] CFG_BIT_PHASE_TICKS = 2'd2;
    localparam logic [1:0] CFG_READ_TAIL_TICKS = 2'd3;

    localparam logic [7:0] RST_ACK_POLL_LIMIT  = 8'd250;
    localparam logic [7:0] RST_START_STOP_HOLD = 8'd4;
    localparam logic [7:0] RST_BIT_PHASE_TICKS = 8'd2;
    localparam logic [7:0] RST_READ_TAIL_TICKS = 8'd1;

    localparam logic [7:0] PTC_MAX    = 8'd255;
    localparam logic [3:0] BITS_BYTE  = 4'd8;

    typedef struct packed {
        logic [7:0] ack_poll_limit;
        logic [7:0] start_stop_hold;
        logic [7:0] bit_phase_ticks;
        logic [7:0] read_tail_ticks;
    } t_cfg;

    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] opcode;
        logic [7:0] tx_byte;
        logic       ack_after_read;
        logic       sda_in;
    } t_tick;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive_enable;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_failed;
    } t_result;

    typedef struct packed {
        logic [3:0] step;
        logic [7:0] ptc;
        logic [3:0] bidx;
        logic [7:0] shreg;
        logic [7:0] poll;
        logic       ackc;
        logic       fail;
        logic       scl;
        logic       sda;
        logic       oe;
        logic [7:0] rx;
    } t_st;

    function automatic logic [7:0] f_phase_len(input logic [3:0] step, input t_cfg cfg);
        logic [7:0] len;
        if (step == S_ST_A || step == S_ST_B || step == S_SP_A || step == S_SP_B) begin
            len = cfg.start_stop_hold;
        end else if (step == S_RD_H) begin
            len = cfg.read_tail_ticks;
        end else begin
            len = cfg.bit_phase_ticks;
        end
        return len;
    endfunction

    // Enter a step: clear the phase counter and set its pins; S_RD_H also shifts in a bit.
    function automatic t_st f_enter(input t_st s, input logic [3:0] step, input logic sda_now);
        t_st r;
        r      = s;
        r.step = step;
        r.ptc  = '0;
        unique case (step)
            S_ST_A: begin r.oe = 1'b1; r.sda = 1'b1; r.scl = 1'b1; end
            S_ST_B: r.sda = 1'b0;
            S_SP_A: begin r.oe = 1'b1; r.scl = 1'b0; r.sda = 1'b0; end
            S_SP_B: r.scl = 1'b1;
            S_TX_D: begin r.oe = 1'b1; r.scl = 1'b0; r.sda = s.shreg[7]; end
            S_TX_H: r.scl = 1'b1;
            S_TX_L: r.scl = 1'b0;
            S_WA_R: begin r.oe = 1'b0; r.sda = 1'b1; end
            S_WA_H: r.scl = 1'b1;
            S_RD_L: begin r.oe = 1'b0; r.scl = 1'b0; end
            S_RD_H: begin
                r.scl   = 1'b1;
                r.shreg = {s.shreg[6:0], sda_now};
                r.bidx  = s.bidx + 4'd1;
            end
            S_RK_L: begin r.scl = 1'b0; r.oe = 1'b1; r.sda = !s.ackc; end
            S_RK_H: r.scl = 1'b1;
            default: r.step = step;
        endcase
        return r;
    endfunction

    // One acknowledge poll: low SDA ends the wait, too many highs fail into a stop.
    function automatic t_st f_poll(input t_st s, input logic sda_now, input logic [7:0] limit);
        t_st r;
        r = s;
        if (!sda_now) begin
            r.scl  = 1'b0;
            r.step = S_IDLE;
            r.ptc  = '0;
        end else if (s.poll >= limit) begin
            r.fail = 1'b1;
            r      = f_enter(r, S_SP_A, sda_now);
        end else begin
            r.poll = s.poll + 8'd1;
        end
        return r;
    endfunction

endpackage

// ----- sv/i2cbm_fsm.sv -----
// Sequencer state of the I2C master bit engine: one tick per enable.
// Depends on i2cbm_pkg; the result of the tick is combinational, the state registered.
module i2cbm_fsm (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  i2cbm_pkg::t_cfg    i_cfg,
    input  i2cbm_pkg::t_tick   i_tick,
    output i2cbm_pkg::t_result o_res
);

    i2cbm_pkg::t_st r_st;
    i2cbm_pkg::t_st n_st;
    logic           n_done;

    always_comb begin
        i2cbm_pkg::t_st v;
        logic [7:0]     ptc_inc;
        logic [3:0]     b;
        v       = r_st;
        n_done  = 1'b0;
        ptc_inc = (r_st.ptc < i2cbm_pkg::PTC_MAX) ? r_st.ptc + 8'd1 : r_st.ptc;
        b       = r_st.bidx + 4'd1;
        if (r_st.step == i2cbm_pkg::S_IDLE) begin
            // commands are only taken here; anything above read is dropped
            if (i_tick.cmd_valid && i_tick.opcode <= i2cbm_pkg::OP_READ) begin
                v.bidx = '0;
                v.poll = '0;
                unique case (i_tick.opcode)
                    i2cbm_pkg::OP_START: v = i2cbm_pkg::f_enter(v, i2cbm_pkg::S_ST_A, i_tick.sda_in);
                    i2cbm_pkg::OP_STOP:  v = i2cbm_pkg::f_enter(v, i2cbm_pkg::S_SP_A, i_tick.sda_in);
                    i2cbm_pkg::OP_SEND: begin
                        v.shreg = i_tick.tx_byte;
                        v       = i2cbm_pkg::f_enter(v, i2cbm_pkg::S_TX_D, i_tick.sda_in);
                    end
                    i2cbm_pkg::OP_WACK: begin
                        v.fail = 1'b0;
                        v      = i2cbm_pkg::f_enter(v, i2cbm_pkg::S_WA_R, i_tick.sda_in);
                    end
                    default: begin
                        v.ackc  = i_tick.ack_after_read;
                        v.shreg = '0;
                        v       = i2cbm_pkg::f_enter(v, i2cbm_pkg::S_RD_L, i_tick.sda_in);
                    end
                endcase
            end
        end else if (r_st.step == i2cbm_pkg::S_WA_P) begin
            v      = i2cbm_pkg::f_poll(r_st, i_tick.sda_in, i_cfg.ack_poll_limit);
            n_done = !i_tick.sda_in;
        end else begin
            v.ptc = ptc_inc;
            if (ptc_inc >= i2cbm_pkg::f_phase_len(r_st.step, i_cfg)) begin
                unique case (r_st.step)
                    i2cbm_pkg::S_ST_A: v = i2cbm_pkg::f_enter(v, i2cbm_pkg::S_ST_B, i_tick.sda_in);
                    i2cbm_pkg::S_ST_B: begin
                        v.scl  = 1'b0;
                        v.step = i2cbm_pkg::S_IDLE;
                        v.ptc  = '0;
                        n_done = 1'b1;
                    end
                    i2cbm_pkg::S_SP_A: v = i2cbm_pkg::f_enter(v, i2cbm_pkg::S_SP_B, i_tick.sda_in);
                    i2cbm_pkg::S_SP_B: begin
                        v.sda  = 1'b1;
                        v.step = i2cbm_pkg::S_IDLE;
                        v.ptc  = '0;
                        n_done = 1'b1;
                    end
                    i2cbm_pkg::S_TX_D: v = i2cbm_pkg::f_enter(v, i2cbm_pkg::S_TX_H, i_tick.sda_in);
                    i2cbm_pkg::S_TX_H: v = i2cbm_pkg::f_enter(v, i2cbm_pkg::S_TX_L, i_tick.sda_in);
                    i2cbm_pkg::S_TX_L: begin
                        v.bidx = b;
                        if (b >= i2cbm_pkg::BITS_BYTE) begin
                            v.step = i2cbm_pkg::S_IDLE;
                            v.ptc  = '0;
                            n_done = 1'b1;
                        end else begin
                            // advance to the next bit, MSB first
                            v.shreg = {r_st.shreg[6:0], 1'b0};
                            v       = i2cbm_pkg::f_enter(v, i2cbm_pkg::S_TX_D, i_tick.sda_in);
                        end
                    end
                    i2cbm_pkg::S_WA_R: v = i2cbm_pkg::f_enter(v, i2cbm_pkg::S_WA_H, i_tick.sda_in);
                    i2cbm_pkg::S_WA_H: begin
                        // the first poll falls on the tick SCL high ends
                        v      = i2cbm_pkg::f_enter(v, i2cbm_pkg::S_WA_P, i_tick.sda_in);
                        v      = i2cbm_pkg::f_poll(v, i_tick.sda_in, i_cfg.ack_poll_limit);
                        n_done = !i_tick.sda_in;
                    end
                    i2cbm_pkg::S_RD_L: v = i2cbm_pkg::f_enter(v, i2cbm_pkg::S_RD_H, i_tick.sda_in);
                    i2cbm_pkg::S_RD_H: begin
                        if (r_st.bidx >= i2cbm_pkg::BITS_BYTE) begin
                            v = i2cbm_pkg::f_enter(v, i2cbm_pkg::S_RK_L, i_tick.sda_in);
                        end else begin
                            v = i2cbm_pkg::f_enter(v, i2cbm_pkg::S_RD_L, i_tick.sda_in);
                        end
                    end
                    i2cbm_pkg::S_RK_L: v = i2cbm_pkg::f_enter(v, i2cbm_pkg::S_RK_H, i_tick.sda_in);
                    i2cbm_pkg::S_RK_H: begin
                        v.scl  = 1'b0;
                        v.rx   = r_st.shreg;
                        v.step = i2cbm_pkg::S_IDLE;
                        v.ptc  = '0;
                        n_done = 1'b1;
                    end
                    default: begin
                        v.step = i2cbm_pkg::S_IDLE;
                        v.ptc  = '0;
                    end
                endcase
            end
        end
        n_st = v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.step  <= i2cbm_pkg::S_IDLE;
            r_st.ptc   <= '0;
            r_st.bidx  <= '0;
            r_st.shreg <= '0;
            r_st.poll  <= '0;
            r_st.ackc  <= 1'b0;
            r_st.fail  <= 1'b0;
            r_st.scl   <= 1'b1;
            r_st.sda   <= 1'b1;
            r_st.oe    <= 1'b1;
            r_st.rx    <= '0;
        end else if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_res.scl_level        = n_st.scl;
    assign o_res.sda_level        = n_st.sda;
    assign o_res.sda_drive_enable = n_st.oe;
    assign o_res.busy_res         = (n_st.step != i2cbm_pkg::S_IDLE);
    assign o_res.done_res         = n_done;
    assign o_res.rx_byte          = n_st.rx;
    assign o_res.ack_failed       = n_st.fail;

endmodule

// ----- sv/i2c_bit_level_master.sv -----
// I2C master bit engine, top level. Each tick beat enters the input register, then its
// result the result register once it is empty or not stalled. Throughput: one beat
// per cycle unless the result channel stalls, limited by the single sequencer update.
// Reset (synchronous, active low) empties both registers, idles the sequencer, sets
// SCL high and SDA high driven, clears rx byte and failure flag and loads default phases.
// Depends on i2cbm_pkg, i2cbm_fsm and i2c_bit_level_master_defines.svh.
`include "i2c_bit_level_master_defines.svh"

module i2c_bit_level_master (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // tick channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_cmd_valid,
    input  logic [2:0] i_opcode,
    input  logic [7:0] i_tx_byte,
    input  logic       i_ack_after_read,
    input  logic       i_sda_in,
    // result channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_scl_level,
    output logic       o_sda_level,
    output logic       o_sda_drive_enable,
    output logic       o_busy_res,
    output logic       o_done_res,
    output logic [7:0] o_rx_byte,
    output logic       o_ack_failed,
    // configuration
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    i2cbm_pkg::t_cfg    r_cfg;
    i2cbm_pkg::t_tick   r_in;
    logic               r_in_valid;
    i2cbm_pkg::t_result r_out;
    logic               r_out_valid;
    i2cbm_pkg::t_result w_res;
    logic               w_out_free;
    logic               w_adv;
    logic               w_in_take;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_adv      = r_in_valid && w_out_free;
    assign o_in_stall = r_in_valid && !w_out_free;
    assign w_in_take  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ack_poll_limit  <= i2cbm_pkg::RST_ACK_POLL_LIMIT;
            r_cfg.start_stop_hold <= i2cbm_pkg::RST_START_STOP_HOLD;
            r_cfg.bit_phase_ticks <= i2cbm_pkg::RST_BIT_PHASE_TICKS;
            r_cfg.read_tail_ticks <= i2cbm_pkg::RST_READ_TAIL_TICKS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                i2cbm_pkg::CFG_ACK_POLL_LIMIT:  r_cfg.ack_poll_limit  <= i_cfg_data;
                i2cbm_pkg::CFG_START_STOP_HOLD: r_cfg.start_stop_hold <= i_cfg_data;
                i2cbm_pkg::CFG_BIT_PHASE_TICKS: r_cfg.bit_phase_ticks <= i_cfg_data;
                i2cbm_pkg::CFG_READ_TAIL_TICKS: r_cfg.read_tail_ticks <= i_cfg_data;
            endcase
        end
    end

    // input register: fill when empty and refill whenever the held beat moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in.cmd_valid      <= i_cmd_valid;
            r_in.opcode         <= i_opcode;
            r_in.tx_byte        <= i_tx_byte;
            r_in.ack_after_read <= i_ack_after_read;
            r_in.sda_in         <= i_sda_in;
        end
    end

    i2cbm_fsm u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_cfg   (r_cfg),
        .i_tick  (r_in),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_scl_level        = r_out.scl_level;
    assign o_sda_level        = r_out.sda_level;
    assign o_sda_drive_enable = r_out.sda_drive_enable;
    assign o_busy_res         = r_out.busy_res;
    assign o_done_res         = r_out.done_res;
    assign o_rx_byte          = r_out.rx_byte;
    assign o_ack_failed       = r_out.ack_failed;

    `I2CBM_ASSERT_NOW(a_done_not_busy, i_clk, i_rst_n, r_out_valid && r_out.done_res, !r_out.busy_res)
    `I2CBM_ASSERT_NEXT(a_adv_gives_beat, i_clk, i_rst_n, w_adv, r_out_valid)
    `I2CBM_ASSERT_NOW(a_stall_only_full, i_clk, i_rst_n, o_in_stall, r_in_valid && r_out_valid)

endmodule
